// ===== rtl/mcrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcrb_pkg;

    // action codes
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_POLL = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NODATA = 3'd3;
    localparam logic [2:0] ST_ABSENT = 3'd4;

    localparam logic [7:0] LSR_NO_DEVICE = 8'hFF;

    localparam logic [3:0] POLL_IN_MASK  = 4'b0011;
    localparam logic [3:0] POLL_OUT_MASK = 4'b1100;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic exec;      // evaluate, update pointers, access the byte store
        logic load_out;  // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken this cycle
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/mcrb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/mcrb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcrb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire mcrb_pkg::t_sts i_sts,
    output mcrb_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_WB;
            end
            S_WB: begin
                // hold the result until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/mcrb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcrb_dp #(
    parameter int BUFFER_DEPTH  = 1024,
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mcrb_pkg::t_cmd i_cmd,
    output mcrb_pkg::t_sts      o_sts,
    input  wire logic [3:0]     i_present_mask,
    input  wire logic [1:0]     i_action,
    input  wire logic [1:0]     i_channel,
    input  wire logic [7:0]     i_rx_status,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic [3:0]     i_poll_request,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_read_byte,
    output logic [2:0]          o_status,
    output logic                o_event_flag,
    output logic [3:0]          o_poll_result
);

    localparam int PW   = $clog2(BUFFER_DEPTH);
    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int SD   = CHANNEL_COUNT * BUFFER_DEPTH;
    localparam int AW   = $clog2(SD);
    localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH - 1);

    // captured transaction
    logic [1:0] r_action;
    logic [1:0] r_channel;
    logic [7:0] r_rx_status;
    logic [7:0] r_rx_byte;
    logic [3:0] r_poll_request;

    // ring state
    logic [PW-1:0] r_rd_ptr [CHANNEL_COUNT];
    logic [PW-1:0] r_wr_ptr [CHANNEL_COUNT];
    logic          r_event  [CHANNEL_COUNT];

    // staged result waiting for the store read
    logic [2:0] r_res_status;
    logic       r_res_event;
    logic [3:0] r_res_poll;
    logic       r_res_pop;

    // output register
    logic       r_out_valid;
    logic [7:0] r_read_byte;
    logic [2:0] r_status;
    logic       r_event_flag;
    logic [3:0] r_poll_result;

    logic [CH_W-1:0] ch_idx;
    logic            ch_ok;
    logic            present;
    logic [PW-1:0]   rp;
    logic [PW-1:0]   wp;
    logic [PW-1:0]   rp_inc;
    logic [PW-1:0]   wp_inc;
    logic [PW-1:0]   n_rd_ptr;
    logic [PW-1:0]   n_wr_ptr;
    logic            n_event;
    logic            rd_upd;
    logic            wr_upd;
    logic            ev_upd;
    logic [2:0]      n_res_status;
    logic [3:0]      n_res_poll;
    logic            n_res_pop;
    logic            ram_en;
    logic            ram_we;
    logic [PW-1:0]   ram_ptr;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_rdata;

    assign ch_idx  = CH_W'(r_channel);
    assign ch_ok   = (32'(r_channel) < CHANNEL_COUNT);
    assign present = ch_ok && i_present_mask[r_channel];
    assign rp      = r_rd_ptr[ch_idx];
    assign wp      = r_wr_ptr[ch_idx];
    assign rp_inc  = (rp == PTR_LAST) ? '0 : rp + 1'b1;
    assign wp_inc  = (wp == PTR_LAST) ? '0 : wp + 1'b1;

    always_comb begin
        n_res_status = mcrb_pkg::ST_OK;
        n_res_poll   = '0;
        n_res_pop    = 1'b0;
        n_rd_ptr     = rp_inc;
        n_wr_ptr     = wp_inc;
        n_event      = ch_ok ? r_event[ch_idx] : 1'b0;
        rd_upd       = 1'b0;
        wr_upd       = 1'b0;
        ev_upd       = 1'b0;
        ram_we       = 1'b0;
        ram_ptr      = rp;
        if (r_action != mcrb_pkg::ACT_NOP && !present) begin
            n_res_status = mcrb_pkg::ST_ABSENT;
        end else begin
            case (r_action)
                mcrb_pkg::ACT_PUSH: begin
                    if (!r_rx_status[0] || r_rx_status == mcrb_pkg::LSR_NO_DEVICE) begin
                        n_res_status = mcrb_pkg::ST_NODATA;
                    end else begin
                        // event is raised even when the byte is dropped
                        ev_upd  = 1'b1;
                        n_event = 1'b1;
                        if (wp_inc == rp) begin
                            n_res_status = mcrb_pkg::ST_FULL;
                        end else begin
                            wr_upd  = 1'b1;
                            ram_we  = 1'b1;
                            ram_ptr = wp;
                        end
                    end
                end
                mcrb_pkg::ACT_POP: begin
                    if (rp == wp) begin
                        n_res_status = mcrb_pkg::ST_EMPTY;
                        ev_upd       = 1'b1;
                        n_event      = 1'b0;
                    end else begin
                        rd_upd    = 1'b1;
                        n_res_pop = 1'b1;
                    end
                end
                mcrb_pkg::ACT_POLL: begin
                    n_res_poll = r_poll_request & mcrb_pkg::POLL_OUT_MASK;
                    if (rp != wp) begin
                        n_res_poll = r_poll_request;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign ram_en   = i_cmd.exec && (ram_we || n_res_pop);
    assign ram_addr = AW'(32'(ch_idx) * BUFFER_DEPTH + 32'(ram_ptr));

    mcrb_ram #(
        .WIDTH(8),
        .DEPTH(SD)
    ) u_store (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_rx_byte),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action       <= i_action;
            r_channel      <= i_channel;
            r_rx_status    <= i_rx_status;
            r_rx_byte      <= i_rx_byte;
            r_poll_request <= i_poll_request;
        end
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
            r_res_event  <= n_event;
            r_res_poll   <= n_res_poll;
            r_res_pop    <= n_res_pop;
        end
        if (i_cmd.load_out) begin
            r_read_byte   <= r_res_pop ? ram_rdata : 8'd0;
            r_status      <= r_res_status;
            r_event_flag  <= r_res_event;
            r_poll_result <= r_res_poll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_rd_ptr[c] <= '0;
                r_wr_ptr[c] <= '0;
                r_event[c]  <= 1'b0;
            end
        end else if (i_cmd.exec && ch_ok) begin
            if (rd_upd) begin
                r_rd_ptr[ch_idx] <= n_rd_ptr;
            end
            if (wr_upd) begin
                r_wr_ptr[ch_idx] <= n_wr_ptr;
            end
            if (ev_upd) begin
                r_event[ch_idx] <= n_event;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_read_byte    = r_read_byte;
    assign o_status       = r_status;
    assign o_event_flag   = r_event_flag;
    assign o_poll_result  = r_poll_result;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_receive_ring_buffer.sv =====
// Receive ring buffers for up to CHANNEL_COUNT serial channels in one shared byte store.
// Input channel (i_in_valid / o_in_stall): one transaction carries an action (push,
// pop, poll or no-op), a channel number, a line status, a received byte and a poll
// request. Output channel (o_out_valid / i_out_stall): one result per transaction
// with the popped byte, a status code, the channel event flag and the poll result.
// Each transaction goes through capture, evaluation with store access, and load
// into the output register; the next transaction is taken the cycle after the
// result is loaded, so no new transaction is accepted while one is in flight.
// The byte store is single-port with a registered read.
// A stalled receiver holds the result in the output register; one more transaction
// is evaluated behind it and then waits until the output register frees up.
// Reset (i_rst_n low, synchronous) empties all rings, clears the event flags and
// marks all channels present; byte store contents are not cleared.
// The APB port holds the channel present mask at byte address 0.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_receive_ring_buffer #(
    parameter int BUFFER_DEPTH  = 1024,
    parameter int CHANNEL_COUNT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_channel,
    input  wire logic [7:0]  i_rx_status,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [3:0]  i_poll_request,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_byte,
    output logic [2:0]       o_status,
    output logic             o_event_flag,
    output logic [3:0]       o_poll_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_PRESENT_MASK = 1'b0;

    logic [3:0]     r_present_mask;
    logic           cfg_wr;
    mcrb_pkg::t_cmd cmd;
    mcrb_pkg::t_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_mask <= 4'hF;
        end else if (cfg_wr && paddr[2] == REG_PRESENT_MASK) begin
            r_present_mask <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == REG_PRESENT_MASK) ? {28'd0, r_present_mask} : 32'd0;

    mcrb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    mcrb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_present_mask(r_present_mask),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_rx_status   (i_rx_status),
        .i_rx_byte     (i_rx_byte),
        .i_poll_request(i_poll_request),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_byte   (o_read_byte),
        .o_status      (o_status),
        .o_event_flag  (o_event_flag),
        .o_poll_result (o_poll_result)
    );

endmodule

`default_nettype wire
